// File: rtl/lpp_pkg.sv
// Package: shared constants and types for the lidar point packet parser.
`default_nettype none

package lpp_pkg;

    // Packet layout
    localparam int HEADER_BYTES     = 42;
    localparam int BLOCKS           = 12;
    localparam int POINTS_PER_BLOCK = 32;

    localparam int HDR_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int BLK_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int PT_W  = (POINTS_PER_BLOCK > 1) ? $clog2(POINTS_PER_BLOCK) : 1;

    localparam logic [HDR_W-1:0] HDR_LAST =
        HDR_W'((HEADER_BYTES > 0) ? HEADER_BYTES - 1 : 0);
    localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCKS - 1);
    localparam logic [PT_W-1:0]  PT_LAST  = PT_W'(POINTS_PER_BLOCK - 1);

    // Marker register reset value
    localparam logic [15:0] MARKER_RESET = 16'hFFEE;

    // Result kinds
    localparam logic [1:0] KIND_POINT   = 2'd0;
    localparam logic [1:0] KIND_TRAILER = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Byte slots in the block preamble
    localparam logic [1:0] OFF_MARK_HI = 2'd0;
    localparam logic [1:0] OFF_MARK_LO = 2'd1;
    localparam logic [1:0] OFF_AZ_LO   = 2'd2;
    localparam logic [1:0] OFF_AZ_HI   = 2'd3;

    // Byte slots in a point
    localparam logic [1:0] SUB_DIST_LO = 2'd0;
    localparam logic [1:0] SUB_DIST_HI = 2'd1;
    localparam logic [1:0] SUB_REFL    = 2'd2;

    // Byte slots in the trailer
    localparam logic [2:0] TRL_TS_LAST = 3'd3;
    localparam logic [2:0] TRL_FAC_LO  = 3'd4;
    localparam logic [2:0] TRL_FAC_HI  = 3'd5;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_DROP    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_MARK    = 5'b00100,
        PH_POINT   = 5'b01000,
        PH_TRAILER = 5'b10000
    } phase_t;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  blk;
        logic [4:0]  pt;
        logic [15:0] az;
        logic [15:0] distance;
        logic [7:0]  refl;
        logic [31:0] ts;
        logic [15:0] fac;
        logic        pkt_end;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/lpp_parser.sv
// Byte-position tracker and field decoder for the lidar packet parser.
`default_nettype none

module lpp_parser
    import lpp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_fire,
    input  wire logic [7:0]  data_byte,
    input  wire logic        packet_start,
    input  wire logic [15:0] block_marker,
    output logic             res_valid,
    output result_t          res
);

    // Position state: describes where the next byte lands
    phase_t           phase_reg, phase_next;
    logic [HDR_W-1:0] hdr_reg, hdr_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [1:0]       off_reg, off_next;
    logic [PT_W-1:0]  pt_reg, pt_next;
    logic [1:0]       sub_reg, sub_next;
    logic [2:0]       trl_reg, trl_next;

    // Field holding registers
    logic [7:0]  marker_high_reg, marker_high_next;
    logic [15:0] azimuth_reg, azimuth_next;
    logic [15:0] distance_reg, distance_next;
    logic [31:0] time_reg, time_next;
    logic [7:0]  factory_low_reg, factory_low_next;

    // Effective position of the current byte (start byte forces position zero)
    phase_t           cur_phase;
    logic [HDR_W-1:0] cur_hdr;
    logic [BLK_W-1:0] cur_blk;
    logic [1:0]       cur_off;
    logic [PT_W-1:0]  cur_pt;
    logic [1:0]       cur_sub;
    logic [2:0]       cur_trl;

    always_comb
    begin
        cur_phase = phase_reg;
        cur_hdr   = hdr_reg;
        cur_blk   = blk_reg;
        cur_off   = off_reg;
        cur_pt    = pt_reg;
        cur_sub   = sub_reg;
        cur_trl   = trl_reg;
        if (packet_start)
        begin
            if (HEADER_BYTES > 0)
                cur_phase = PH_HEADER;
            else
                cur_phase = PH_MARK;
            cur_hdr = '0;
            cur_blk = '0;
            cur_off = OFF_MARK_HI;
            cur_pt  = '0;
            cur_sub = SUB_DIST_LO;
            cur_trl = '0;
        end
    end

    // Decode the byte and step the position
    always_comb
    begin
        phase_next       = cur_phase;
        hdr_next         = cur_hdr;
        blk_next         = cur_blk;
        off_next         = cur_off;
        pt_next          = cur_pt;
        sub_next         = cur_sub;
        trl_next         = cur_trl;
        marker_high_next = marker_high_reg;
        azimuth_next     = azimuth_reg;
        distance_next    = distance_reg;
        time_next        = time_reg;
        factory_low_next = factory_low_reg;
        res_valid        = 1'b0;
        res              = '0;

        unique case (cur_phase)
            PH_DROP:
            begin
                // idle bytes are ignored
            end
            PH_HEADER:
            begin
                if (cur_hdr == HDR_LAST)
                begin
                    phase_next = PH_MARK;
                    blk_next   = '0;
                    off_next   = OFF_MARK_HI;
                end
                else
                begin
                    hdr_next = cur_hdr + 1'b1;
                end
            end
            PH_MARK:
            begin
                off_next = cur_off + 1'b1;
                case (cur_off)
                    OFF_MARK_HI: marker_high_next = data_byte;
                    OFF_MARK_LO:
                    begin
                        if ({marker_high_reg, data_byte} != block_marker)
                        begin
                            phase_next  = PH_DROP;
                            res_valid   = 1'b1;
                            res.kind    = KIND_ERROR;
                            res.blk     = 4'(cur_blk);
                            res.pkt_end = 1'b1;
                        end
                    end
                    OFF_AZ_LO: azimuth_next[7:0] = data_byte;
                    default:
                    begin
                        azimuth_next[15:8] = data_byte;
                        phase_next         = PH_POINT;
                        pt_next            = '0;
                        sub_next           = SUB_DIST_LO;
                    end
                endcase
            end
            PH_POINT:
            begin
                case (cur_sub)
                    SUB_DIST_LO:
                    begin
                        distance_next[7:0] = data_byte;
                        sub_next           = SUB_DIST_HI;
                    end
                    SUB_DIST_HI:
                    begin
                        distance_next[15:8] = data_byte;
                        sub_next            = SUB_REFL;
                    end
                    default:
                    begin
                        res_valid    = 1'b1;
                        res.kind     = KIND_POINT;
                        res.blk      = 4'(cur_blk);
                        res.pt       = 5'(cur_pt);
                        res.az       = azimuth_reg;
                        res.distance = distance_reg;
                        res.refl     = data_byte;
                        sub_next     = SUB_DIST_LO;
                        if (cur_pt == PT_LAST)
                        begin
                            if (cur_blk == BLK_LAST)
                            begin
                                phase_next = PH_TRAILER;
                                trl_next   = '0;
                            end
                            else
                            begin
                                phase_next = PH_MARK;
                                blk_next   = cur_blk + 1'b1;
                                off_next   = OFF_MARK_HI;
                            end
                        end
                        else
                        begin
                            pt_next = cur_pt + 1'b1;
                        end
                    end
                endcase
            end
            PH_TRAILER:
            begin
                trl_next = cur_trl + 1'b1;
                if (cur_trl <= TRL_TS_LAST)
                begin
                    time_next[8*cur_trl[1:0] +: 8] = data_byte;
                end
                else if (cur_trl == TRL_FAC_LO)
                begin
                    factory_low_next = data_byte;
                end
                else
                begin
                    phase_next  = PH_DROP;
                    res_valid   = 1'b1;
                    res.kind    = KIND_TRAILER;
                    res.ts      = time_reg;
                    res.fac     = {data_byte, factory_low_reg};
                    res.pkt_end = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_DROP;
            end
        endcase
    end

    // Position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DROP;
            hdr_reg   <= '0;
            blk_reg   <= '0;
            off_reg   <= OFF_MARK_HI;
            pt_reg    <= '0;
            sub_reg   <= SUB_DIST_LO;
            trl_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            blk_reg   <= blk_next;
            off_reg   <= off_next;
            pt_reg    <= pt_next;
            sub_reg   <= sub_next;
            trl_reg   <= trl_next;
        end
    end

    // Field bytes, always written before they are used
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            marker_high_reg <= marker_high_next;
            azimuth_reg     <= azimuth_next;
            distance_reg    <= distance_next;
            time_reg        <= time_next;
            factory_low_reg <= factory_low_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lidar_point_packet_parser_core.sv
// Top level of the lidar point packet parser: handshakes, marker register, result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one payload byte per request,
//   with packet_start flagging the first byte of a packet. Output channel
//   (out_valid/out_ready) carries point, trailer and marker-error results.
//   cfg_wr_en/cfg_wr_data write the expected block marker (reset 0xFFEE);
//   write it only while no packet is in flight.
// Throughput: one byte per cycle, set by the single output register, when not stalled;
//   the byte decode itself finishes in the cycle the request is accepted.
// Output: a result is in the output register in the cycle after the byte that
//   completes it (third byte of a point, last trailer byte, second byte of a bad marker).
// Reset: parser waits for a packet_start byte; bytes before it are dropped.
// Stall: while a result sits unread and out_ready is low, in_ready is low;
//   when out_ready is high a new byte is taken in the same cycle the held
//   result leaves. At most one result per byte.
`default_nettype none

module lidar_point_packet_parser_core
    import lpp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        packet_start,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    // result output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [3:0]       block_index,
    output logic [4:0]       point_index,
    output logic [15:0]      azimuth,
    output logic [15:0]      distance,
    output logic [7:0]       reflectivity,
    output logic [31:0]      time_stamp,
    output logic [15:0]      factory_word,
    output logic             packet_end
);

    logic [15:0] block_marker_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     result_reg;
    logic        in_fire;
    logic        res_valid;
    result_t     res;

    // Marker register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            block_marker_reg <= MARKER_RESET;
        else if (cfg_wr_en)
            block_marker_reg <= cfg_wr_data;
    end

    // Accept when the result slot is free or drains this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    lpp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .data_byte    (data_byte),
        .packet_start (packet_start),
        .block_marker (block_marker_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_ready)
            out_valid_next = in_fire && res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
            result_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = result_reg.kind;
    assign block_index  = result_reg.blk;
    assign point_index  = result_reg.pt;
    assign azimuth      = result_reg.az;
    assign distance     = result_reg.distance;
    assign reflectivity = result_reg.refl;
    assign time_stamp   = result_reg.ts;
    assign factory_word = result_reg.fac;
    assign packet_end   = result_reg.pkt_end;

    // Checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("in_ready low with empty result register");

    a_end_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (packet_end == (result_kind != KIND_POINT)))
        else $error("packet_end does not match result kind");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_kind == KIND_POINT || result_kind == KIND_TRAILER ||
                           result_kind == KIND_ERROR))
        else $error("illegal result kind");

    a_block_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_kind != KIND_TRAILER) |-> (block_index < 4'(BLOCKS)))
        else $error("block index out of range");

    a_no_result_without_request: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !in_fire) |=> !out_valid_reg)
        else $error("result appeared without an accepted byte");

endmodule

`default_nettype wire
